FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/rqnh_pkg.sv
// Types and constants of the ray/quad nearest-hit pipeline.
package rqnh_pkg;

    localparam int DATA_W    = 32;             // Q16.16 coordinate
    localparam int S_W       = 33;             // vertex difference, signed
    localparam int SMAG_W    = 32;             // magnitude of a vertex difference
    localparam int NT_W      = 66;             // t numerator magnitude
    localparam int DEN_W     = 65;             // denominator magnitude
    localparam int PROD_W    = NT_W + DATA_W;  // nt * |d|
    localparam int COORD_QW  = 42;             // overflow flag + 41 quotient bits
    localparam int CAP_SHIFT = 40;             // offset cap is 2^40
    localparam int LEN2_W    = 2 * SMAG_W + 1; // sx^2 + sy^2
    localparam int NDIV_W    = 2 * SMAG_W + 32;// c^2 * 2^32
    localparam int NORM_QW   = 33;             // c^2 * 2^32 / len2 <= 2^32
    localparam int SQRT_W    = 17;             // root <= 65536
    localparam int NORM_W    = 18;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_VTX   = 8;
    localparam int EDGE_LAT  = 3;
    localparam int PICK_LAT  = 2;
    localparam int PREP_LAT  = 2;
    localparam int PAD_LAT   = NORM_QW + SQRT_W - COORD_QW;

    typedef struct packed {
        logic signed [DATA_W-1:0] ox;
        logic signed [DATA_W-1:0] oy;
        logic signed [DATA_W-1:0] dx;
        logic signed [DATA_W-1:0] dy;
    } t_ray;

    // One edge candidate; as the running best, hit means found.
    typedef struct packed {
        logic                  hit;
        logic [NT_W-1:0]       nt;
        logic [DEN_W-1:0]      den;
        logic signed [S_W-1:0] sx;
        logic signed [S_W-1:0] sy;
    } t_cand;

endpackage

FILE: hw/rtl/rqnh_edge_cell.sv
// Per-edge front end: cross products, sign fix and hit test.
module rqnh_edge_cell
    import rqnh_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_ax,
    input  logic signed [DATA_W-1:0] i_ay,
    input  logic signed [DATA_W-1:0] i_bx,
    input  logic signed [DATA_W-1:0] i_by,
    input  t_ray                     i_ray,
    output t_cand                    o_cand
);

    // stage 1
    logic signed [S_W-1:0]    r_sx1, r_sy1, r_qx, r_qy;
    logic signed [DATA_W-1:0] r_rx, r_ry;
    // stage 2
    logic signed [DATA_W+S_W-1:0] r_rs1, r_rs2, r_qr1, r_qr2;
    logic signed [2*S_W-1:0]      r_qs1, r_qs2;
    logic signed [S_W-1:0]        r_sx2, r_sy2;
    // stage 3
    t_cand r_cand;

    logic signed [DATA_W+S_W:0] den, nu, nu_f, den_f;
    logic signed [2*S_W:0]      nt, nt_f;
    logic                       dneg;

    always_comb begin
        den   = (DATA_W+S_W+1)'(r_rs1) - (DATA_W+S_W+1)'(r_rs2);
        nt    = (2*S_W+1)'(r_qs1) - (2*S_W+1)'(r_qs2);
        nu    = (DATA_W+S_W+1)'(r_qr1) - (DATA_W+S_W+1)'(r_qr2);
        dneg  = den[DATA_W+S_W];
        den_f = dneg ? -den : den;
        nt_f  = dneg ? -nt  : nt;
        nu_f  = dneg ? -nu  : nu;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx1 <= S_W'(i_bx) - S_W'(i_ax);
            r_sy1 <= S_W'(i_by) - S_W'(i_ay);
            r_qx  <= S_W'(i_ax) - S_W'(i_ray.ox);
            r_qy  <= S_W'(i_ay) - S_W'(i_ray.oy);
            r_rx  <= i_ray.dx;
            r_ry  <= i_ray.dy;

            r_rs1 <= r_rx * r_sy1;
            r_rs2 <= r_ry * r_sx1;
            r_qs1 <= r_qx * r_sy1;
            r_qs2 <= r_qy * r_sx1;
            r_qr1 <= r_qx * r_ry;
            r_qr2 <= r_qy * r_rx;
            r_sx2 <= r_sx1;
            r_sy2 <= r_sy1;

            // parallel edge is a miss; t >= 0 and 0 <= u <= 1 otherwise
            r_cand.hit <= (den != '0) && !nt_f[2*S_W] && !nu_f[DATA_W+S_W]
                          && (nu_f <= den_f);
            r_cand.nt  <= nt_f[NT_W-1:0];
            r_cand.den <= den_f[DEN_W-1:0];
            r_cand.sx  <= r_sx2;
            r_cand.sy  <= r_sy2;
        end
    end

    assign o_cand = r_cand;

endmodule

FILE: hw/rtl/rqnh_pick_cell.sv
// Nearest-hit chain cell: compares one edge against the running best.
module rqnh_pick_cell
    import rqnh_pkg::*;
#(
    parameter int NE  = 4,
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_cand            i_best,
    input  t_cand [NE-1:0]   i_cands,
    input  t_ray             i_ray,
    output t_cand            o_best,
    output t_cand [NE-1:0]   o_cands,
    output t_ray             o_ray
);

    localparam int NH = NT_W - 33;   // nt split: hi NH bits, lo 33 bits
    localparam int DH = DEN_W - 33;  // den split: hi DH bits, lo 33 bits
    localparam int PW = NT_W + DEN_W;

    t_cand            r_best1, r_cand1, r_best2;
    t_cand [NE-1:0]   r_cands1, r_cands2;
    t_ray             r_ray1, r_ray2;
    logic [NH+DH-1:0] r_lhh, r_rhh, r_llh, r_rlh;
    logic [NH+32:0]   r_lhl, r_rhl;
    logic [65:0]      r_lll, r_rll;

    logic [PW-1:0] lhs, rhs;
    t_cand         cand;
    logic          take;

    function automatic logic [PW-1:0] sum4(input logic [NH+DH-1:0] hh,
                                           input logic [NH+32:0] hl,
                                           input logic [NH+DH-1:0] lh,
                                           input logic [65:0] ll);
        sum4 = (PW'(hh) << 66) + (PW'(hl) << 33) + (PW'(lh) << 33) + PW'(ll);
    endfunction

    assign cand = i_cands[IDX];

    always_comb begin
        lhs  = sum4(r_lhh, r_lhl, r_llh, r_lll);   // cand.nt * best.den
        rhs  = sum4(r_rhh, r_rhl, r_rlh, r_rll);   // best.nt * cand.den
        // strict less: ties stay with the earlier edge
        take = r_cand1.hit && (!r_best1.hit || (lhs < rhs));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lhh <= cand.nt[NT_W-1:33] * i_best.den[DEN_W-1:33];
            r_lhl <= cand.nt[NT_W-1:33] * i_best.den[32:0];
            r_llh <= cand.nt[32:0]      * i_best.den[DEN_W-1:33];
            r_lll <= cand.nt[32:0]      * i_best.den[32:0];
            r_rhh <= i_best.nt[NT_W-1:33] * cand.den[DEN_W-1:33];
            r_rhl <= i_best.nt[NT_W-1:33] * cand.den[32:0];
            r_rlh <= i_best.nt[32:0]      * cand.den[DEN_W-1:33];
            r_rll <= i_best.nt[32:0]      * cand.den[32:0];
            r_best1  <= i_best;
            r_cand1  <= cand;
            r_cands1 <= i_cands;
            r_ray1   <= i_ray;

            r_best2  <= take ? r_cand1 : r_best1;
            r_cands2 <= r_cands1;
            r_ray2   <= r_ray1;
        end
    end

    assign o_best  = r_best2;
    assign o_cands = r_cands2;
    assign o_ray   = r_ray2;

endmodule

FILE: hw/rtl/rqnh_div_cell.sv
// One restoring-division step: settles one quotient bit.
module rqnh_div_cell #(
    parameter int RW    = 98,
    parameter int DW    = 65,
    parameter int QW    = 42,
    parameter int SHIFT = 0,
    parameter int SB_W  = 1
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [RW-1:0]   i_rem,
    input  logic [DW-1:0]   i_div,
    input  logic [QW-1:0]   i_quo,
    input  logic [SB_W-1:0] i_sb,
    output logic [RW-1:0]   o_rem,
    output logic [DW-1:0]   o_div,
    output logic [QW-1:0]   o_quo,
    output logic [SB_W-1:0] o_sb
);

    localparam int TW = ((RW > DW + SHIFT) ? RW : DW + SHIFT) + 1;

    logic [RW-1:0]   r_rem;
    logic [DW-1:0]   r_div;
    logic [QW-1:0]   r_quo;
    logic [SB_W-1:0] r_sb;
    logic [TW-1:0]   rem_x, trial, diff;
    logic            ge;

    always_comb begin
        rem_x = TW'(i_rem);
        trial = TW'(i_div) << SHIFT;
        ge    = rem_x >= trial;
        diff  = rem_x - trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= ge ? diff[RW-1:0] : i_rem;
            r_quo <= i_quo | (QW'(ge) << SHIFT);
            r_div <= i_div;
            r_sb  <= i_sb;
        end
    end

    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = r_quo;
    assign o_sb  = r_sb;

endmodule

FILE: hw/rtl/rqnh_sqrt_cell.sv
// One integer square-root step: decides one root bit.
module rqnh_sqrt_cell #(
    parameter int VW   = 33,
    parameter int RTW  = 17,
    parameter int BIT  = 0,
    parameter int SB_W = 1
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [VW-1:0]   i_val,
    input  logic [RTW-1:0]  i_root,
    input  logic [SB_W-1:0] i_sb,
    output logic [VW-1:0]   o_val,
    output logic [RTW-1:0]  o_root,
    output logic [SB_W-1:0] o_sb
);

    localparam int CW = (2 * RTW > VW) ? 2 * RTW : VW;

    logic [VW-1:0]    r_val;
    logic [RTW-1:0]   r_root;
    logic [SB_W-1:0]  r_sb;
    logic [RTW-1:0]   trial;
    logic [2*RTW-1:0] sq;

    always_comb begin
        trial = i_root | (RTW'(1) << BIT);
        sq    = trial * trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= (CW'(sq) <= CW'(i_val)) ? trial : i_root;
            r_val  <= i_val;
            r_sb   <= i_sb;
        end
    end

    assign o_val  = r_val;
    assign o_root = r_root;
    assign o_sb   = r_sb;

endmodule

FILE: hw/rtl/ray_quad_nearest_hit.sv
// Top level of the ray / closed-polygon nearest-hit pipeline.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+--------------------------------------
//  s_*      | in  | s_tvalid / s_tready    | ray: origin_x, origin_y, dir_x, dir_y
//  m_*      | out | m_tvalid / m_tready    | hit point, unit normal; tuser = hit
//  i_cfg_*  | in  | i_cfg_valid/o_cfg_ready| vertex register write
//
//  One ray per cycle sustained while the skid stage is empty. A ray passes the
//  edge cells, the pick chain, the prep registers, the restoring divider and
//  root cells (one result bit per cell) and the final assembly register on its
//  way to the output register. Reset (synchronous, active low) clears valids
//  and the vertex registers. A stalled result sits in the output register and
//  one more in a skid stage; s_tready drops only once the skid stage is full.
module ray_quad_nearest_hit
    import rqnh_pkg::*;
#(
    parameter int NUM_EDGES = 4   // 3 or 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // ray in, fields from bit 0: origin_x, origin_y, dir_x, dir_y
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [127:0]         s_tdata,
    // result out, fields from bit 0: hit_x, hit_y, normal_x, normal_y, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [103:0]         m_tdata,
    // result flags, from bit 0: hit
    output logic                 m_tuser,
    // vertex registers: index 0..7 = v0x, v0y, v1x, v1y, v2x, v2y, v3x, v3y
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int LAT = EDGE_LAT + PICK_LAT * NUM_EDGES + PREP_LAT
                         + NORM_QW + SQRT_W + 1;
    localparam logic [COORD_QW-2:0] OFF_CAP = (COORD_QW-1)'(1) << CAP_SHIFT;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] hx;
        logic signed [DATA_W-1:0] hy;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
    } t_res;

    // ---------------- configuration ----------------
    logic signed [DATA_W-1:0] r_vtx [NUM_VTX];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_VTX; k++) r_vtx[k] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vtx[i_cfg_index] <= i_cfg_data;
        end
    end

    // ---------------- flow control ----------------
    // Whole pipeline advances together; only a full skid stage stops it.
    logic r_skid_vld, r_out_vld;
    logic en;
    logic [LAT-1:0] r_vld;

    assign en       = !r_skid_vld;
    assign s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_tvalid};
        end
    end

    // ---------------- edge front ends ----------------
    t_ray in_ray;
    t_ray r_ray_d [EDGE_LAT];
    t_cand [NUM_EDGES-1:0] cand_w;

    assign in_ray = '{ox: s_tdata[31:0], oy: s_tdata[63:32],
                      dx: s_tdata[95:64], dy: s_tdata[127:96]};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ray_d[0] <= in_ray;
            for (int k = 1; k < EDGE_LAT; k++) r_ray_d[k] <= r_ray_d[k-1];
        end
    end

    for (genvar g = 0; g < NUM_EDGES; g++) begin : g_edge
        localparam int IB = (g + 1) % NUM_EDGES;
        rqnh_edge_cell u_edge (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_ax   (r_vtx[2*g]),
            .i_ay   (r_vtx[2*g+1]),
            .i_bx   (r_vtx[2*IB]),
            .i_by   (r_vtx[2*IB+1]),
            .i_ray  (in_ray),
            .o_cand (cand_w[g])
        );
    end

    // ---------------- pick chain ----------------
    t_cand                 best_w  [NUM_EDGES+1];
    t_cand [NUM_EDGES-1:0] cands_w [NUM_EDGES+1];
    t_ray                  ray_w   [NUM_EDGES+1];

    assign best_w[0]  = '0;
    assign cands_w[0] = cand_w;
    assign ray_w[0]   = r_ray_d[EDGE_LAT-1];

    for (genvar g = 0; g < NUM_EDGES; g++) begin : g_pick
        rqnh_pick_cell #(.NE(NUM_EDGES), .IDX(g)) u_pick (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_best  (best_w[g]),
            .i_cands (cands_w[g]),
            .i_ray   (ray_w[g]),
            .o_best  (best_w[g+1]),
            .o_cands (cands_w[g+1]),
            .o_ray   (ray_w[g+1])
        );
    end

    // ---------------- prep: products, len^2 ----------------
    t_cand bst;
    t_ray  bray;
    logic [SMAG_W-1:0] dmx, dmy, smx, smy;

    assign bst  = best_w[NUM_EDGES];
    assign bray = ray_w[NUM_EDGES];

    always_comb begin
        dmx = bray.dx[DATA_W-1] ? SMAG_W'(-bray.dx) : SMAG_W'(bray.dx);
        dmy = bray.dy[DATA_W-1] ? SMAG_W'(-bray.dy) : SMAG_W'(bray.dy);
        smx = bst.sx[S_W-1] ? SMAG_W'(-bst.sx) : SMAG_W'(bst.sx);
        smy = bst.sy[S_W-1] ? SMAG_W'(-bst.sy) : SMAG_W'(bst.sy);
    end

    logic [NT_W-33+SMAG_W-1:0] r_phx, r_phy;
    logic [33+SMAG_W-1:0]      r_plx, r_ply;
    logic [2*SMAG_W-1:0]       r_c2x, r_c2y;
    logic [DEN_W-1:0]          r_den1, r_den2;
    t_ray                      r_pray1, r_pray2;
    logic                      r_fnd1, r_fnd2, r_sxn1, r_sxn2, r_syp1, r_syp2;
    logic [PROD_W-1:0]         r_prx, r_pry;
    logic [LEN2_W-1:0]         r_len2;
    logic [NDIV_W-1:0]         r_ndx, r_ndy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_phx   <= bst.nt[NT_W-1:33] * dmx;
            r_plx   <= bst.nt[32:0] * dmx;
            r_phy   <= bst.nt[NT_W-1:33] * dmy;
            r_ply   <= bst.nt[32:0] * dmy;
            r_c2x   <= smx * smx;
            r_c2y   <= smy * smy;
            r_den1  <= bst.den;
            r_pray1 <= bray;
            r_fnd1  <= bst.hit;
            r_sxn1  <= bst.sx[S_W-1];
            r_syp1  <= !bst.sy[S_W-1] && (bst.sy != '0);

            r_prx   <= (PROD_W'(r_phx) << 33) + PROD_W'(r_plx);
            r_pry   <= (PROD_W'(r_phy) << 33) + PROD_W'(r_ply);
            r_len2  <= LEN2_W'(r_c2x) + LEN2_W'(r_c2y);
            r_ndx   <= NDIV_W'(r_c2y) << 32;   // normal_x comes from sy
            r_ndy   <= NDIV_W'(r_c2x) << 32;
            r_den2  <= r_den1;
            r_pray2 <= r_pray1;
            r_fnd2  <= r_fnd1;
            r_sxn2  <= r_sxn1;
            r_syp2  <= r_syp1;
        end
    end

    // ---------------- hit-point dividers ----------------
    // sideband: {dir negative, origin}
    localparam int CSB_W = DATA_W + 1;
    logic [PROD_W-1:0]   cx_rem [COORD_QW+1], cy_rem [COORD_QW+1];
    logic [DEN_W-1:0]    cx_div [COORD_QW+1], cy_div [COORD_QW+1];
    logic [COORD_QW-1:0] cx_quo [COORD_QW+1], cy_quo [COORD_QW+1];
    logic [CSB_W-1:0]    cx_sb  [COORD_QW+1], cy_sb  [COORD_QW+1];

    assign cx_rem[0] = r_prx;
    assign cy_rem[0] = r_pry;
    assign cx_div[0] = r_den2;
    assign cy_div[0] = r_den2;
    assign cx_quo[0] = '0;
    assign cy_quo[0] = '0;
    assign cx_sb[0]  = {r_pray2.dx[DATA_W-1], r_pray2.ox};
    assign cy_sb[0]  = {r_pray2.dy[DATA_W-1], r_pray2.oy};

    for (genvar g = 0; g < COORD_QW; g++) begin : g_cdiv
        rqnh_div_cell #(.RW(PROD_W), .DW(DEN_W), .QW(COORD_QW),
                        .SHIFT(COORD_QW-1-g), .SB_W(CSB_W)) u_cx (
            .i_clk (i_clk), .i_en (en),
            .i_rem (cx_rem[g]), .i_div (cx_div[g]), .i_quo (cx_quo[g]), .i_sb (cx_sb[g]),
            .o_rem (cx_rem[g+1]), .o_div (cx_div[g+1]), .o_quo (cx_quo[g+1]),
            .o_sb (cx_sb[g+1])
        );
        rqnh_div_cell #(.RW(PROD_W), .DW(DEN_W), .QW(COORD_QW),
                        .SHIFT(COORD_QW-1-g), .SB_W(CSB_W)) u_cy (
            .i_clk (i_clk), .i_en (en),
            .i_rem (cy_rem[g]), .i_div (cy_div[g]), .i_quo (cy_quo[g]), .i_sb (cy_sb[g]),
            .o_rem (cy_rem[g+1]), .o_div (cy_div[g+1]), .o_quo (cy_quo[g+1]),
            .o_sb (cy_sb[g+1])
        );
    end

    // align with the longer normal path
    logic [COORD_QW-1:0] r_pqx [PAD_LAT], r_pqy [PAD_LAT];
    logic [CSB_W-1:0]    r_psx [PAD_LAT], r_psy [PAD_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pqx[0] <= cx_quo[COORD_QW];
            r_pqy[0] <= cy_quo[COORD_QW];
            r_psx[0] <= cx_sb[COORD_QW];
            r_psy[0] <= cy_sb[COORD_QW];
            for (int k = 1; k < PAD_LAT; k++) begin
                r_pqx[k] <= r_pqx[k-1];
                r_pqy[k] <= r_pqy[k-1];
                r_psx[k] <= r_psx[k-1];
                r_psy[k] <= r_psy[k-1];
            end
        end
    end

    // ---------------- normal dividers and roots ----------------
    // sideband: {found, component negative}
    localparam int NSB_W = 2;
    logic [NDIV_W-1:0]  nx_rem [NORM_QW+1], ny_rem [NORM_QW+1];
    logic [LEN2_W-1:0]  nx_div [NORM_QW+1], ny_div [NORM_QW+1];
    logic [NORM_QW-1:0] nx_quo [NORM_QW+1], ny_quo [NORM_QW+1];
    logic [NSB_W-1:0]   nx_sb  [NORM_QW+1], ny_sb  [NORM_QW+1];

    assign nx_rem[0] = r_ndx;
    assign ny_rem[0] = r_ndy;
    assign nx_div[0] = r_len2;
    assign ny_div[0] = r_len2;
    assign nx_quo[0] = '0;
    assign ny_quo[0] = '0;
    assign nx_sb[0]  = {r_fnd2, r_syp2};
    assign ny_sb[0]  = {r_fnd2, r_sxn2};

    for (genvar g = 0; g < NORM_QW; g++) begin : g_ndiv
        rqnh_div_cell #(.RW(NDIV_W), .DW(LEN2_W), .QW(NORM_QW),
                        .SHIFT(NORM_QW-1-g), .SB_W(NSB_W)) u_nx (
            .i_clk (i_clk), .i_en (en),
            .i_rem (nx_rem[g]), .i_div (nx_div[g]), .i_quo (nx_quo[g]), .i_sb (nx_sb[g]),
            .o_rem (nx_rem[g+1]), .o_div (nx_div[g+1]), .o_quo (nx_quo[g+1]),
            .o_sb (nx_sb[g+1])
        );
        rqnh_div_cell #(.RW(NDIV_W), .DW(LEN2_W), .QW(NORM_QW),
                        .SHIFT(NORM_QW-1-g), .SB_W(NSB_W)) u_ny (
            .i_clk (i_clk), .i_en (en),
            .i_rem (ny_rem[g]), .i_div (ny_div[g]), .i_quo (ny_quo[g]), .i_sb (ny_sb[g]),
            .o_rem (ny_rem[g+1]), .o_div (ny_div[g+1]), .o_quo (ny_quo[g+1]),
            .o_sb (ny_sb[g+1])
        );
    end

    logic [NORM_QW-1:0] sx_val  [SQRT_W+1], sy_val  [SQRT_W+1];
    logic [SQRT_W-1:0]  sx_root [SQRT_W+1], sy_root [SQRT_W+1];
    logic [NSB_W-1:0]   sx_sb   [SQRT_W+1], sy_sb   [SQRT_W+1];

    assign sx_val[0]  = nx_quo[NORM_QW];
    assign sy_val[0]  = ny_quo[NORM_QW];
    assign sx_root[0] = '0;
    assign sy_root[0] = '0;
    assign sx_sb[0]   = nx_sb[NORM_QW];
    assign sy_sb[0]   = ny_sb[NORM_QW];

    for (genvar g = 0; g < SQRT_W; g++) begin : g_sqrt
        rqnh_sqrt_cell #(.VW(NORM_QW), .RTW(SQRT_W), .BIT(SQRT_W-1-g),
                         .SB_W(NSB_W)) u_rx (
            .i_clk (i_clk), .i_en (en),
            .i_val (sx_val[g]), .i_root (sx_root[g]), .i_sb (sx_sb[g]),
            .o_val (sx_val[g+1]), .o_root (sx_root[g+1]), .o_sb (sx_sb[g+1])
        );
        rqnh_sqrt_cell #(.VW(NORM_QW), .RTW(SQRT_W), .BIT(SQRT_W-1-g),
                         .SB_W(NSB_W)) u_ry (
            .i_clk (i_clk), .i_en (en),
            .i_val (sy_val[g]), .i_root (sy_root[g]), .i_sb (sy_sb[g]),
            .o_val (sy_val[g+1]), .o_root (sy_root[g+1]), .o_sb (sy_sb[g+1])
        );
    end

    // ---------------- final assembly ----------------
    // origin + signed offset, offset capped at 2^40, sum saturated to 32 bits
    function automatic logic signed [DATA_W-1:0] hit_coord(
            input logic [COORD_QW-1:0] q, input logic [CSB_W-1:0] sb);
        logic [COORD_QW-2:0]       v;
        logic signed [COORD_QW:0]  off, sum;
        v = (q[COORD_QW-1] || (q[COORD_QW-2:0] > OFF_CAP)) ? OFF_CAP : q[COORD_QW-2:0];
        off = sb[CSB_W-1] ? -$signed((COORD_QW+1)'(v)) : $signed((COORD_QW+1)'(v));
        sum = (COORD_QW+1)'($signed(sb[DATA_W-1:0])) + off;
        if (sum > (COORD_QW+1)'(32'sh7FFF_FFFF))
            hit_coord = 32'sh7FFF_FFFF;
        else if (sum < -(COORD_QW+1)'(33'sh0_8000_0000))
            hit_coord = 32'sh8000_0000;
        else
            hit_coord = sum[DATA_W-1:0];
    endfunction

    t_res n_fin, r_fin;
    logic [NORM_W-1:0] rx_ext, ry_ext;

    always_comb begin
        rx_ext = NORM_W'(sx_root[SQRT_W]);
        ry_ext = NORM_W'(sy_root[SQRT_W]);
        n_fin  = '0;
        if (sx_sb[SQRT_W][1]) begin
            n_fin.hit = 1'b1;
            n_fin.hx  = hit_coord(r_pqx[PAD_LAT-1], r_psx[PAD_LAT-1]);
            n_fin.hy  = hit_coord(r_pqy[PAD_LAT-1], r_psy[PAD_LAT-1]);
            n_fin.nx  = sx_sb[SQRT_W][0] ? -rx_ext : rx_ext;
            n_fin.ny  = sy_sb[SQRT_W][0] ? -ry_ext : ry_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_fin <= n_fin;
    end

    // ---------------- output register and skid ----------------
    t_res r_out, r_skid;
    logic emit, take;

    assign emit = en && r_vld[LAT-1];
    assign take = r_out_vld && m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || take) begin
            r_out_vld  <= r_skid_vld || emit;
            r_skid_vld <= 1'b0;
        end else if (emit) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || take) begin
            r_out <= r_skid_vld ? r_skid : r_fin;
        end else if (emit) begin
            r_skid <= r_fin;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_out.hit;
    assign m_tdata  = {4'b0, r_out.ny, r_out.nx, r_out.hy, r_out.hx};

endmodule

FILE: hw/rtl/rqnh_checker.sv
// Port-level checker for the nearest-hit block, with its bind.
`include "assert_macros.svh"

module rqnh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tuser
);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // a miss carries an all-zero payload
    `ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, m_tvalid && !m_tuser, m_tdata == 104'd0)
    // input backs up only behind a waiting result
    `ASSERT_IMPLY(a_ready_skid, i_clk, i_rst_n, !s_tready, m_tvalid)
    // normal components stay within one
    `ASSERT_IMPLY(a_norm_range, i_clk, i_rst_n, m_tvalid && m_tuser, ($signed(m_tdata[81:64]) <= 18'sd65536) && ($signed(m_tdata[81:64]) >= -18'sd65536) && ($signed(m_tdata[99:82]) <= 18'sd65536) && ($signed(m_tdata[99:82]) >= -18'sd65536))

endmodule

bind ray_quad_nearest_hit rqnh_checker u_rqnh_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
